/* sv/twn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twn_pkg: shared types and constants of the whitespace normalizer
// Payload structs, the per-item result bundle, byte codes and queue sizing.
// ----------------------------------------------------------------------------
package twn_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} twn_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
	} twn_out_t;

	// up to three results per input byte
	localparam int unsigned TWN_MAX_RES = 3;
	localparam int unsigned TWN_CNT_W   = $clog2(TWN_MAX_RES + 1);

	// results of one input byte, handed from front to back
	typedef struct packed {
		logic [TWN_CNT_W-1:0]          cnt;
		logic                          marker;
		logic                          last;
		logic [TWN_MAX_RES-1:0][7:0]   bytes;
	} twn_bundle_t;

	localparam logic [7:0] QUOTE_B0   = 8'hE2;
	localparam logic [7:0] QUOTE_B1   = 8'h80;
	localparam logic [7:0] QUOTE_B2   = 8'h99;
	localparam logic [7:0] APOSTROPHE = 8'h27;
	localparam logic [7:0] SPACE      = 8'h20;
	localparam logic [7:0] WS_LO      = 8'h09;
	localparam logic [7:0] WS_HI      = 8'h0D;

	localparam int unsigned TWN_QDEPTH = 4;
	localparam int unsigned TWN_QPTR_W = $clog2(TWN_QDEPTH);
	localparam int unsigned TWN_QCNT_W = $clog2(TWN_QDEPTH + 1);

	function automatic logic is_ws(input logic [7:0] b);
		return (b == SPACE) || ((b >= WS_LO) && (b <= WS_HI));
	endfunction

endpackage
`default_nettype wire

/* sv/twn_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twn_front: input classifier
// Tracks text, pending space and quote match state and builds the result
// bundle of each accepted byte for the queue.
// ----------------------------------------------------------------------------
module twn_front import twn_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire twn_in_t     in_data,
	input  wire logic        full,
	output logic             push,
	output twn_bundle_t      push_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_E2,
		ST_E280
	} match_t;

	match_t stage_q, stage_d;
	logic   seen_q, seen_d;
	logic   space_q, space_d;

	logic                        consumed;
	logic [TWN_CNT_W-1:0]        n;
	logic [TWN_MAX_RES-1:0][7:0] res;
	logic                        accept;
	logic                        marker;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		stage_d  = stage_q;
		seen_d   = seen_q;
		space_d  = space_q;
		consumed = 1'b0;
		n        = '0;
		res      = '0;
		marker   = 1'b0;

		unique case (stage_q)
			ST_E2: begin
				if (in_data.in_byte == QUOTE_B1) begin
					stage_d  = ST_E280;
					consumed = 1'b1;
				end else begin
					res[0]  = QUOTE_B0;
					n       = TWN_CNT_W'(1);
					stage_d = ST_IDLE;
				end
			end
			ST_E280: begin
				if (in_data.in_byte == QUOTE_B2) begin
					res[0]   = APOSTROPHE;
					n        = TWN_CNT_W'(1);
					consumed = 1'b1;
				end else begin
					res[0] = QUOTE_B0;
					res[1] = QUOTE_B1;
					n      = TWN_CNT_W'(2);
				end
				stage_d = ST_IDLE;
			end
			default: begin
			end
		endcase

		if (!consumed) begin
			if (is_ws(in_data.in_byte)) begin
				if (seen_q) begin
					space_d = 1'b1;
				end
			end else begin
				if (space_q) begin
					res[n[1:0]] = SPACE;
					n           = n + TWN_CNT_W'(1);
					space_d     = 1'b0;
				end
				seen_d = 1'b1;
				if (in_data.in_byte == QUOTE_B0) begin
					stage_d = ST_E2;
				end else begin
					res[n[1:0]] = in_data.in_byte;
					n           = n + TWN_CNT_W'(1);
				end
			end
		end

		if (in_data.in_last) begin
			// flush a held partial match
			if (stage_d == ST_E2) begin
				res[n[1:0]] = QUOTE_B0;
				n           = n + TWN_CNT_W'(1);
			end else if (stage_d == ST_E280) begin
				res[n[1:0]] = QUOTE_B0;
				n           = n + TWN_CNT_W'(1);
				res[n[1:0]] = QUOTE_B1;
				n           = n + TWN_CNT_W'(1);
			end
			if (n == '0) begin
				marker = 1'b1;
			end
			seen_d  = 1'b0;
			space_d = 1'b0;
			stage_d = ST_IDLE;
		end
	end

	assign push             = accept && ((n != '0) || in_data.in_last);
	assign push_data.cnt    = marker ? TWN_CNT_W'(1) : n;
	assign push_data.marker = marker;
	assign push_data.last   = in_data.in_last;
	assign push_data.bytes  = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_IDLE;
			seen_q  <= 1'b0;
			space_q <= 1'b0;
		end else if (accept) begin
			stage_q <= stage_d;
			seen_q  <= seen_d;
			space_q <= space_d;
		end
	end

	// a pending space needs text before it
	a_space_after_text: assert property (@(posedge clk) disable iff (!arst_n)
		space_q |-> seen_q)
		else $error("space pending without text");

	// a held quote prefix implies text was seen
	a_match_after_text: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q != ST_IDLE) |-> (seen_q && !space_q))
		else $error("quote match state inconsistent");

endmodule
`default_nettype wire

/* sv/twn_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twn_fifo: bundle queue
// Short register queue that decouples the classifier from the serializer.
// ----------------------------------------------------------------------------
module twn_fifo import twn_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire twn_bundle_t push_data,
	output logic             full,
	input  wire logic        pop,
	output twn_bundle_t      head,
	output logic             empty
);

	twn_bundle_t            mem_q [TWN_QDEPTH];
	logic [TWN_QPTR_W-1:0]  wr_q;
	logic [TWN_QPTR_W-1:0]  rd_q;
	logic [TWN_QCNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == TWN_QCNT_W'(TWN_QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + TWN_QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + TWN_QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + TWN_QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - TWN_QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue underflow");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_q - rd_q) == cnt_q[TWN_QPTR_W-1:0])
		else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

/* sv/twn_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twn_back: result serializer
// Walks the head bundle one result per transfer into the output register.
// ----------------------------------------------------------------------------
module twn_back import twn_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        empty,
	input  wire twn_bundle_t head,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output twn_out_t         out_data
);

	logic                 ovld_q;
	twn_out_t             out_q;
	logic [TWN_CNT_W-1:0] idx_q;
	logic                 load;
	logic                 at_end;
	logic [7:0]           sel_byte;

	assign load   = !ovld_q || out_ready;
	assign at_end = (idx_q == (head.cnt - TWN_CNT_W'(1)));
	assign pop    = load && !empty && at_end;

	always_comb begin
		case (idx_q)
			TWN_CNT_W'(0): sel_byte = head.bytes[0];
			TWN_CNT_W'(1): sel_byte = head.bytes[1];
			default:       sel_byte = head.bytes[2];
		endcase
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			out_q.out_byte  <= head.marker ? '0 : sel_byte;
			out_q.out_valid <= !head.marker;
			out_q.out_last  <= head.last && at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			ovld_q <= !empty;
			if (!empty) begin
				idx_q <= at_end ? '0 : idx_q + TWN_CNT_W'(1);
			end
		end
	end

	assign out_valid = ovld_q;
	assign out_data  = out_q;

	// a bare end marker is always the final result of its text
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ovld_q && !out_q.out_valid) |-> (out_q.out_last && (out_q.out_byte == '0)))
		else $error("bare marker without last");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (idx_q < head.cnt))
		else $error("result index past bundle");

endmodule
`default_nettype wire

/* sv/text_whitespace_normalizer_unit.sv */
// Throughput: one input byte per cycle while each byte yields at most one
// result and out_ready is high; a byte yielding k results holds the output
// for k transfers, and a four-entry bundle queue between classifier and
// serializer absorbs such bursts before the output register.
// Reset: arst_n clears match state, queue and output valid flag at once.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_whitespace_normalizer_unit: whitespace collapse, trim, quote fix
// Front classifier, bundle queue and output serializer.
// ----------------------------------------------------------------------------
module text_whitespace_normalizer_unit import twn_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire twn_in_t  in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output twn_out_t      out_data
);

	logic        q_full;
	logic        q_empty;
	logic        q_push;
	logic        q_pop;
	twn_bundle_t q_wdata;
	twn_bundle_t q_head;

	twn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.full      (q_full),
		.push      (q_push),
		.push_data (q_wdata)
	);

	twn_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	twn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
